// File: sv/stereo_lookahead_peak_limiter_macros.svh
// Assertion macros for the stereo look-ahead peak limiter.
// Used by stereo_lookahead_peak_limiter.sv; needs clk_i and rst_ni in scope.
`ifndef STEREO_LOOKAHEAD_PEAK_LIMITER_MACROS_SVH
`define STEREO_LOOKAHEAD_PEAK_LIMITER_MACROS_SVH

// Checked only while out of reset.
`define SLPL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define SLPL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: sv/slpl_pkg.sv
// Package of the stereo look-ahead peak limiter: widths, register indexes
// and the divider request type. No dependencies.
`default_nettype none
package slpl_pkg;
  localparam int SMP_W = 24;
  localparam int MAX_FRAMES = 256;
  localparam int POS_W = $clog2(MAX_FRAMES);
  localparam int ADDR_W = POS_W + 1;
  localparam int DEPTH = 2 * MAX_FRAMES;
  localparam int BF_W = 9;
  localparam int COEF_W = 16;
  localparam int THR_W = 23;
  localparam int RAMP_W = 32;
  localparam int DIV_W = 46;
  localparam int DSR_W = 24;
  localparam int CNT_W = 6;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LVL_ATK   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LVL_REL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_ATK  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_REL  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK     = 3'd5;

  localparam logic [SMP_W-1:0] GAIN_ONE = 24'd8388608;
  localparam logic [RAMP_W-1:0] RAMP_ONE = 32'h8000_0000;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;
endpackage
`default_nettype wire

// File: sv/stereo_lookahead_peak_limiter.sv
// Stereo look-ahead peak limiter, top level.
// The slave channel takes one stereo frame per item, the master channel
// returns one gained frame per item. The configuration port writes the six
// registers (threshold, four smoothing weights, frames per block).
// An ordinary frame passes the states S_MUL and S_OUT on its way to the
// output register; S_OUT waits while the register holds a result that the
// receiver has not taken, and the next frame is accepted only after S_OUT.
// The last frame of a block then runs the block-end work: a 46-step serial
// division for the target gain when the larger of the last two block peaks
// is above the threshold, the gain smoothing, and a second 46-step division
// for the ramp step. Both divisions use the shared serial divider, and no
// item is accepted until the block-end work is done.
// The output is the input delayed by two blocks; the first two blocks are
// zero. After reset the sample memory is cleared in a pass over its 512
// entries, with no item accepted; configuration writes are taken always.
// The result register holds a finished item until the receiver takes it;
// while the receiver stalls, the next item may still be accepted and worked
// on, and the block waits only when a second result is ready.
// Depends on slpl_pkg, slpl_div and the macros header.
`default_nettype none
`include "stereo_lookahead_peak_limiter_macros.svh"
module stereo_lookahead_peak_limiter (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // Input items. tdata: left_sample [23:0], right_sample [47:24].
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire  [2*slpl_pkg::SMP_W-1:0]     s_axis_tdata,
  // Result items. tdata: left_out [23:0], right_out [47:24].
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  output logic [2*slpl_pkg::SMP_W-1:0]     m_axis_tdata,
  // Configuration writes.
  input  wire                              cfg_we_i,
  input  wire  [slpl_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire  [slpl_pkg::THR_W-1:0]       cfg_wdata_i
);
  import slpl_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MUL, S_OUT, S_BLK, S_DIV1, S_GMUL, S_GSUM, S_DIV2
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic [THR_W-1:0]  thr_q;
  logic [COEF_W-1:0] lvl_atk_q, lvl_rel_q, gain_atk_q, gain_rel_q;
  logic [BF_W-1:0]   bf_q;

  // Limiter state.
  logic [SMP_W-1:0]  env_q, peak_q, prev_peak_q, gain_q, target_q;
  logic [RAMP_W-1:0] ramp_q;
  logic signed [RAMP_W:0] step_q;
  logic [POS_W-1:0]  pos_q;
  logic              bank_q;
  logic [ADDR_W-1:0] clr_q;

  // Item in flight.
  logic signed [SMP_W-1:0] l_q, r_q;
  logic [SMP_W-1:0]  lev_q;
  logic [39:0]       p1_q;
  logic [40:0]       p2_q;
  logic signed [56:0] prod_l_q, prod_r_q;
  logic              neg_q;

  // Output register.
  logic              out_valid_q;
  logic [2*SMP_W-1:0] out_data_q;

  // Sample memory, one stereo frame per entry, two banks.
  logic [2*SMP_W-1:0] mem [DEPTH];
  logic [2*SMP_W-1:0] rd_q;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [2*SMP_W-1:0] mem_wdata;

  div_req_t          div_req;
  logic              div_busy, div_done;
  logic [DIV_W-1:0]  div_quot;

  logic accept;
  assign s_axis_tready = (state_q == S_IDLE);
  assign accept = s_axis_tvalid && s_axis_tready;

  // Input magnitude: larger of the two channel magnitudes.
  logic signed [SMP_W-1:0] in_l, in_r;
  logic [SMP_W:0] abs_l, abs_r;
  logic [SMP_W-1:0] lev_in;
  assign in_l  = s_axis_tdata[SMP_W-1:0];
  assign in_r  = s_axis_tdata[2*SMP_W-1:SMP_W];
  assign abs_l = in_l[SMP_W-1] ? -{in_l[SMP_W-1], in_l} : {in_l[SMP_W-1], in_l};
  assign abs_r = in_r[SMP_W-1] ? -{in_r[SMP_W-1], in_r} : {in_r[SMP_W-1], in_r};
  assign lev_in = (abs_l > abs_r) ? abs_l[SMP_W-1:0] : abs_r[SMP_W-1:0];

  // Effective block length, clamped to 1..MAX_FRAMES.
  logic [BF_W-1:0] bf_eff;
  always_comb begin
    if (bf_q == '0) bf_eff = BF_W'(1);
    else if (bf_q > BF_W'(MAX_FRAMES)) bf_eff = BF_W'(MAX_FRAMES);
    else bf_eff = bf_q;
  end

  // Ramp advance with clamping to [0, unity].
  logic signed [RAMP_W+1:0] ramp_sum;
  logic [RAMP_W-1:0] ramp_next;
  assign ramp_sum = $signed({2'b00, ramp_q}) + $signed({step_q[RAMP_W], step_q});
  always_comb begin
    if (ramp_sum[RAMP_W+1]) ramp_next = '0;
    else if (ramp_sum > $signed({2'b00, RAMP_ONE})) ramp_next = RAMP_ONE;
    else ramp_next = ramp_sum[RAMP_W-1:0];
  end

  // Envelope smoothing: weight picked by rising or falling level.
  logic [COEF_W-1:0] lvl_c;
  logic [41:0] env_sum;
  logic [SMP_W-1:0] env_new;
  assign lvl_c   = (lev_q > env_q) ? lvl_atk_q : lvl_rel_q;
  assign env_sum = 42'(p1_q) + 42'(p2_q) + 42'd32768;
  assign env_new = env_sum[39:16];

  // Gain smoothing: attack weight when the gain must fall.
  logic [COEF_W-1:0] gain_c;
  logic [SMP_W-1:0]  gain_new;
  logic signed [SMP_W:0] gdiff;
  logic signed [RAMP_W:0] gdiff_sh;
  logic [RAMP_W-1:0] gmag;
  assign gain_c   = (gain_q > target_q) ? gain_atk_q : gain_rel_q;
  assign gain_new = env_sum[39:16];
  assign gdiff    = $signed({1'b0, gain_new}) - $signed({1'b0, gain_q});
  assign gdiff_sh = {gdiff, 8'd0};
  assign gmag     = gdiff_sh[RAMP_W] ? RAMP_W'(-gdiff_sh) : gdiff_sh[RAMP_W-1:0];

  // Rounding and saturation of the gained samples.
  function automatic logic [SMP_W-1:0] sat_round(input logic signed [56:0] p);
    logic signed [56:0] t;
    logic signed [25:0] v;
    t = p + 57'sd1073741824;
    v = 26'(t >>> 31);
    if (v > 26'sd8388607) return 24'h7F_FFFF;
    else if (v < -26'sd8388608) return 24'h80_0000;
    else return v[SMP_W-1:0];
  endfunction

  logic block_end;
  assign block_end = ({1'b0, pos_q} + BF_W'(1)) >= bf_eff;

  logic [SMP_W-1:0] pk;
  assign pk = (peak_q > prev_peak_q) ? peak_q : prev_peak_q;

  logic out_free;
  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    div_req = '0;
    if (state_q == S_BLK && pk > {1'b0, thr_q}) begin
      div_req.start    = 1'b1;
      div_req.dividend = {thr_q, 23'd0};
      div_req.divisor  = pk;
    end else if (state_q == S_GSUM) begin
      div_req.start    = 1'b1;
      div_req.dividend = DIV_W'(gmag);
      div_req.divisor  = DSR_W'(bf_eff);
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {bank_q, pos_q};
    mem_wdata = {r_q, l_q};
    if (state_q == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
    end else if (state_q == S_MUL) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (accept) rd_q <= mem[{bank_q, pos_q}];
  end

  slpl_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .busy_o (div_busy),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      thr_q       <= 23'd7717519;
      lvl_atk_q   <= 16'd19661;
      lvl_rel_q   <= 16'd45875;
      gain_atk_q  <= 16'd6554;
      gain_rel_q  <= 16'd39322;
      bf_q        <= 9'd240;
      env_q       <= 24'd4194304;
      peak_q      <= '0;
      prev_peak_q <= '0;
      gain_q      <= '0;
      target_q    <= '0;
      ramp_q      <= '0;
      step_q      <= '0;
      pos_q       <= '0;
      bank_q      <= 1'b0;
      clr_q       <= '0;
      l_q         <= '0;
      r_q         <= '0;
      lev_q       <= '0;
      p1_q        <= '0;
      p2_q        <= '0;
      prod_l_q    <= '0;
      prod_r_q    <= '0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_THRESHOLD: thr_q      <= cfg_wdata_i;
          CFG_LVL_ATK:   lvl_atk_q  <= cfg_wdata_i[COEF_W-1:0];
          CFG_LVL_REL:   lvl_rel_q  <= cfg_wdata_i[COEF_W-1:0];
          CFG_GAIN_ATK:  gain_atk_q <= cfg_wdata_i[COEF_W-1:0];
          CFG_GAIN_REL:  gain_rel_q <= cfg_wdata_i[COEF_W-1:0];
          CFG_BLOCK:     bf_q       <= cfg_wdata_i[BF_W-1:0];
          default: ;
        endcase
      end

      // A new result takes the register as the old one leaves.
      if (state_q == S_OUT && out_free) out_valid_q <= 1'b1;
      else if (out_valid_q && m_axis_tready) out_valid_q <= 1'b0;

      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == ADDR_W'(DEPTH - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            l_q     <= in_l;
            r_q     <= in_r;
            lev_q   <= lev_in;
            ramp_q  <= ramp_next;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          // Stored frame is in rd_q; the new frame goes to the same entry.
          p1_q     <= lvl_c * env_q;
          p2_q     <= (17'd65536 - {1'b0, lvl_c}) * lev_q;
          prod_l_q <= $signed(rd_q[SMP_W-1:0]) * $signed({1'b0, ramp_q});
          prod_r_q <= $signed(rd_q[2*SMP_W-1:SMP_W]) * $signed({1'b0, ramp_q});
          state_q  <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_data_q  <= {sat_round(prod_r_q), sat_round(prod_l_q)};
            env_q       <= env_new;
            if (env_new > peak_q) peak_q <= env_new;
            if (block_end) begin
              state_q <= S_BLK;
            end else begin
              pos_q   <= pos_q + 1'b1;
              state_q <= S_IDLE;
            end
          end
        end
        S_BLK: begin
          prev_peak_q <= peak_q;
          peak_q      <= '0;
          if (pk > {1'b0, thr_q}) begin
            state_q <= S_DIV1;
          end else begin
            target_q <= GAIN_ONE;
            state_q  <= S_GMUL;
          end
        end
        S_DIV1: begin
          if (div_done) begin
            target_q <= div_quot[SMP_W-1:0];
            state_q  <= S_GMUL;
          end
        end
        S_GMUL: begin
          p1_q    <= gain_c * gain_q;
          p2_q    <= (17'd65536 - {1'b0, gain_c}) * target_q;
          state_q <= S_GSUM;
        end
        S_GSUM: begin
          // The ramp restarts exactly at the old gain.
          ramp_q  <= {gain_q, 8'd0};
          gain_q  <= gain_new;
          neg_q   <= gdiff_sh[RAMP_W];
          state_q <= S_DIV2;
        end
        S_DIV2: begin
          if (div_done) begin
            step_q  <= neg_q ? -$signed({1'b0, div_quot[RAMP_W-1:0]})
                             : $signed({1'b0, div_quot[RAMP_W-1:0]});
            pos_q   <= '0;
            bank_q  <= ~bank_q;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `SLPL_ASSERT(a_div_only_at_block_end, div_busy |-> (state_q == S_DIV1 || state_q == S_DIV2), "divider busy outside block-end work")
  `SLPL_ASSERT(a_accept_starts_item, accept |=> (state_q == S_MUL), "accepted item did not start")
  `SLPL_ASSERT_ALWAYS(a_ramp_in_range, ramp_q <= RAMP_ONE, "ramp gain above unity")
  `SLPL_ASSERT(a_no_accept_while_clear, (state_q == S_CLEAR) |-> !s_axis_tready, "item taken during clear")
endmodule
`default_nettype wire

// File: sv/slpl_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on slpl_pkg.
`default_nettype none
module slpl_div (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire slpl_pkg::div_req_t    req_i,
  output logic                       busy_o,
  output logic                       done_o,
  output logic [slpl_pkg::DIV_W-1:0] quot_o
);
  import slpl_pkg::*;

  logic [DSR_W-1:0] rem_q;
  logic [DIV_W-1:0] quo_q;
  logic [DSR_W-1:0] dsr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [DSR_W:0]   rem_sh, rem_sub;
  logic             ge;

  assign rem_sh  = {rem_q, quo_q[DIV_W-1]};
  assign ge      = rem_sh >= {1'b0, dsr_q};
  assign rem_sub = rem_sh - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      quo_q  <= '0;
      dsr_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        rem_q  <= '0;
        quo_q  <= req_i.dividend;
        dsr_q  <= req_i.divisor;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= ge ? rem_sub[DSR_W-1:0] : rem_sh[DSR_W-1:0];
        quo_q <= {quo_q[DIV_W-2:0], ge};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quo_q;
endmodule
`default_nettype wire
